// File: sv/qmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmd_pkg
// Shared widths, types, register codes and the sine magnitude function for
// the QPSK minimum-distance symbol decoder.
// ----------------------------------------------------------------------------
package qmd_pkg;

    localparam int PHASE_BITS_DEF  = 16;
    localparam int SINE_DEPTH_DEF  = 1024;

    localparam int SAMPLE_W   = 32;
    localparam int SPB_W      = 16;
    localparam int STEP_W     = 16;
    localparam int AMP_W      = 31;
    localparam int MAG_W      = 15;
    localparam int SUM_W      = 50;
    localparam int ABSD_W     = 32;
    localparam int SYM_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_REF    = 4;

    localparam logic [SPB_W-1:0]  SPB_RST  = 16'd8;
    localparam logic [STEP_W-1:0] STEP_RST = 16'd0;
    localparam logic [AMP_W-1:0]  AMP_RST  = 31'h7F00_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPB  = 2'd0,
        CFG_STEP = 2'd1,
        CFG_AMP  = 2'd2
    } t_cfg_idx;

    typedef enum logic [SYM_W-1:0] {
        SYM_3PI4 = 2'd0,
        SYM_PI4  = 2'd1,
        SYM_5PI4 = 2'd2,
        SYM_7PI4 = 2'd3
    } t_symbol;

    typedef struct packed {
        logic [SPB_W-1:0]  samples_per_baud;
        logic [STEP_W-1:0] phase_step;
        logic [AMP_W-1:0]  amplitude;
    } t_cfg;

    // sample plus the two signed references at 3/8 and 1/8 turn;
    // the 5/8 and 7/8 references are their negatives
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] sref0;
        logic signed [SAMPLE_W-1:0] sref1;
        logic                       end_baud;
        logic                       fin;
    } t_acc_in;

    typedef struct packed {
        logic [NUM_REF-1:0][SUM_W-1:0] sum;
        logic                          fin;
    } t_baud_sums;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // quarter-wave sine magnitude, r is the in-quadrant position in Q30 quarter turns
    function automatic logic [MAG_W-1:0] sine_mag(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned m;
        x  = (r * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t) >> 30) / 110);
        t  = Q30_ONE - (((x2 * t) >> 30) / 72);
        t  = Q30_ONE - (((x2 * t) >> 30) / 42);
        t  = Q30_ONE - (((x2 * t) >> 30) / 20);
        t  = Q30_ONE - (((x2 * t) >> 30) / 6);
        s  = (x * t) >> 30;
        m  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
        if (m > 64'd32767) begin
            m = 64'd32767;
        end
        return MAG_W'(m);
    endfunction

endpackage

// File: sv/qmd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmd_ifs
// Valid/ready channels: sample requests, symbol results, register writes.
// ----------------------------------------------------------------------------
interface qmd_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qmd_pkg::SAMPLE_W-1:0]  sample;
    logic                                 final_sample;

    modport source (output valid, output sample, output final_sample, input ready);
    modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

interface qmd_symbol_if;
    logic                         valid;
    logic                         ready;
    logic [qmd_pkg::SYM_W-1:0]    symbol;
    logic                         stream_end;

    modport source (output valid, output symbol, output stream_end, input ready);
    modport sink   (input valid, input symbol, input stream_end, output ready);
endinterface

interface qmd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [qmd_pkg::CFG_IDX_W-1:0]    index;
    logic [qmd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/qmd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmd_cfg_regs
// Configuration register file: baud length, phase step, amplitude.
// ----------------------------------------------------------------------------
module qmd_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qmd_cfg_if.sink        i_cfg,
    output qmd_pkg::t_cfg  o_cfg
);

    qmd_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.samples_per_baud <= qmd_pkg::SPB_RST;
            r_cfg.phase_step       <= qmd_pkg::STEP_RST;
            r_cfg.amplitude        <= qmd_pkg::AMP_RST;
        end else if (w_wr) begin
            unique case (qmd_pkg::t_cfg_idx'(i_cfg.index))
                qmd_pkg::CFG_SPB: begin
                    r_cfg.samples_per_baud <= i_cfg.data[qmd_pkg::SPB_W-1:0];
                end
                qmd_pkg::CFG_STEP: begin
                    r_cfg.phase_step <= i_cfg.data[qmd_pkg::STEP_W-1:0];
                end
                qmd_pkg::CFG_AMP: begin
                    r_cfg.amplitude <= i_cfg.data[qmd_pkg::AMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && (i_cfg.index == qmd_pkg::CFG_AMP))
        |=> (r_cfg.amplitude == $past(i_cfg.data[qmd_pkg::AMP_W-1:0])))
        else $error("amplitude write lost");

endmodule

// File: sv/qmd_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmd_sine_rom
// Quarter-wave sine magnitude ROM, two registered read ports.
// ----------------------------------------------------------------------------
module qmd_sine_rom #(
    parameter int SINE_TABLE_DEPTH = qmd_pkg::SINE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-2:0]  i_addr_a,
    input  logic [$clog2(SINE_TABLE_DEPTH)-2:0]  i_addr_b,
    output logic [qmd_pkg::MAG_W-1:0]            o_mag_a,
    output logic [qmd_pkg::MAG_W-1:0]            o_mag_b
);

    localparam int LD    = $clog2(SINE_TABLE_DEPTH);
    localparam int ROM_N = SINE_TABLE_DEPTH / 4 + 1;

    typedef logic [qmd_pkg::MAG_W-1:0] t_rom [ROM_N];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int j = 0; j < ROM_N; j++) begin
            rom[j] = qmd_pkg::sine_mag(64'(j) << (32 - LD));
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [qmd_pkg::MAG_W-1:0] r_mag_a;
    logic [qmd_pkg::MAG_W-1:0] r_mag_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag_a <= ROM[i_addr_a];
            r_mag_b <= ROM[i_addr_b];
        end
    end

    assign o_mag_a = r_mag_a;
    assign o_mag_b = r_mag_b;

endmodule

// File: sv/qmd_dist_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmd_dist_acc
// Absolute distance to the four references, per-baud sums, hand-off of the
// closed sums to the decision stage.
// ----------------------------------------------------------------------------
module qmd_dist_acc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  qmd_pkg::t_acc_in     i_req,
    output logic                 o_ready,
    output logic                 o_valid,
    output qmd_pkg::t_baud_sums  o_sums,
    input  logic                 i_ready
);

    localparam int NR = qmd_pkg::NUM_REF;
    localparam int SW = qmd_pkg::SUM_W;
    localparam int AD = qmd_pkg::ABSD_W;

    logic signed [AD:0]           w_diff [NR];
    logic [AD:0]                  w_absx [NR];
    logic [NR-1:0][AD-1:0]        r_ad;
    logic                         r_v3;
    logic                         r_end3;
    logic                         r_fin3;
    logic [NR-1:0][SW-1:0]        r_sum;
    logic [NR-1:0][SW-1:0]        n_sum;
    logic                         r_v4;
    qmd_pkg::t_baud_sums          r_out;
    logic                         w_rdy4;
    logic                         w_adv3;

    always_comb begin
        w_diff[0] = (AD+1)'(i_req.sample) - (AD+1)'(i_req.sref0);
        w_diff[1] = (AD+1)'(i_req.sample) - (AD+1)'(i_req.sref1);
        w_diff[2] = (AD+1)'(i_req.sample) + (AD+1)'(i_req.sref1);
        w_diff[3] = (AD+1)'(i_req.sample) + (AD+1)'(i_req.sref0);
        for (int k = 0; k < NR; k++) begin
            w_absx[k] = w_diff[k][AD] ? (AD+1)'(-w_diff[k]) : (AD+1)'(w_diff[k]);
        end
        for (int k = 0; k < NR; k++) begin
            n_sum[k] = r_sum[k] + SW'(r_ad[k]);
        end
    end

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_adv3  = r_v3 && (!r_end3 || w_rdy4);
    assign o_ready = !r_v3 || w_adv3;
    assign o_valid = r_v4;
    assign o_sums  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_sum <= '0;
        end else begin
            if (o_ready) begin
                r_v3 <= i_valid;
            end
            if (w_adv3) begin
                r_sum <= r_end3 ? '0 : n_sum;
            end
            if (w_rdy4) begin
                r_v4 <= w_adv3 && r_end3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            for (int k = 0; k < NR; k++) begin
                r_ad[k] <= w_absx[k][AD-1:0];
            end
            r_end3 <= i_req.end_baud;
            r_fin3 <= i_req.fin;
        end
        if (w_adv3 && r_end3) begin
            r_out.sum <= n_sum;
            r_out.fin <= r_fin3;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv3 && r_end3) |=> (r_sum == '0))
        else $error("sums not cleared at end of baud");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v4 && !(w_adv3 && r_end3)) |=> !r_v4)
        else $error("decision raised without a closed baud");

endmodule

// File: sv/qmd_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qmd_decide
// Minimum-sum selection (ties to the later candidate) and result register.
// ----------------------------------------------------------------------------
module qmd_decide (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  qmd_pkg::t_baud_sums  i_sums,
    output logic                 o_ready,
    qmd_symbol_if.source         o_sym
);

    qmd_pkg::t_symbol              w_a;
    qmd_pkg::t_symbol              w_b;
    qmd_pkg::t_symbol              w_win;
    logic [qmd_pkg::SUM_W-1:0]     w_sa;
    logic [qmd_pkg::SUM_W-1:0]     w_sb;
    logic                          w_rdy_out;
    logic                          r_ov;
    qmd_pkg::t_symbol              r_symbol;
    logic                          r_stream_end;

    always_comb begin
        if (i_sums.sum[0] < i_sums.sum[1]) begin
            w_a  = qmd_pkg::SYM_3PI4;
            w_sa = i_sums.sum[0];
        end else begin
            w_a  = qmd_pkg::SYM_PI4;
            w_sa = i_sums.sum[1];
        end
        if (i_sums.sum[2] < i_sums.sum[3]) begin
            w_b  = qmd_pkg::SYM_5PI4;
            w_sb = i_sums.sum[2];
        end else begin
            w_b  = qmd_pkg::SYM_7PI4;
            w_sb = i_sums.sum[3];
        end
        w_win = (w_sa < w_sb) ? w_a : w_b;
    end

    assign w_rdy_out = !r_ov || o_sym.ready;
    assign o_ready   = w_rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_rdy_out) begin
            r_ov <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out && i_valid) begin
            r_symbol     <= w_win;
            r_stream_end <= i_sums.fin;
        end
    end

    assign o_sym.valid      = r_ov;
    assign o_sym.symbol     = r_symbol;
    assign o_sym.stream_end = r_stream_end;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && w_rdy_out) |=> r_ov)
        else $error("closed baud not moved to result register");

endmodule

// File: sv/qpsk_min_distance_symbol_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpsk_min_distance_symbol_decoder
// QPSK minimum-distance decoder: sums |sample - reference| for four carrier
// phases over each baud and returns the symbol of the smallest sum.
//
//   port    dir  handshake     payload
//   i_smp   in   valid/ready   sample (s32), final_sample
//   o_sym   out  valid/ready   symbol (2b), stream_end
//   i_cfg   in   valid/ready   index (2b), data (32b); ready tied high
//
// One sample request per clock unless a stall on o_sym fills the pipeline.
// Pipeline: ROM read, amplitude multiply, distance, accumulate, decision,
// registered in that order. Sine table must be a power of two deep.
// Reset clears phase, baud count, sums and all valids; no clearing pass.
// Requests keep flowing while a symbol waits on o_sym, until the pipeline
// stages in front of the stalled result are full.
// ----------------------------------------------------------------------------
module qpsk_min_distance_symbol_decoder #(
    parameter int PHASE_BITS       = qmd_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = qmd_pkg::SINE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qmd_sample_if.sink    i_smp,
    qmd_symbol_if.source  o_sym,
    qmd_cfg_if.sink       i_cfg
);

    localparam int PB = PHASE_BITS;
    localparam int LD = $clog2(SINE_TABLE_DEPTH);
    localparam int AW = LD - 1;
    localparam int QD = SINE_TABLE_DEPTH / 4;
    localparam int SW = qmd_pkg::SAMPLE_W;
    localparam int MW = qmd_pkg::MAG_W;
    localparam int PW = qmd_pkg::AMP_W + MW;

    // lane 0: 3/8 turn, lane 1: 1/8 turn
    localparam logic [PB-1:0] REF_OFF [2] = '{
        PB'(3) << (PB - 3),
        PB'(1) << (PB - 3)
    };

    qmd_pkg::t_cfg                w_cfg;
    logic [PB-1:0]                r_phase;
    logic [PB-1:0]                w_step;
    logic [qmd_pkg::SPB_W-1:0]    r_cnt;
    logic [qmd_pkg::SPB_W-1:0]    n_cnt;
    logic [qmd_pkg::SPB_W-1:0]    w_spb;
    logic                         w_end;
    logic                         w_acc;

    logic [PB-1:0]                w_ph   [2];
    logic [PB+LD-1:0]             w_wide [2];
    logic [LD-1:0]                w_idx  [2];
    logic [AW-1:0]                w_addr [2];
    logic [1:0]                   w_neg;

    logic                         w_rdy1;
    logic                         w_rdy2;
    logic                         w_rdy3;
    logic                         r_v1;
    logic signed [SW-1:0]         r_smp1;
    logic                         r_fin1;
    logic                         r_end1;
    logic [1:0]                   r_neg1;
    logic [MW-1:0]                w_mag  [2];

    logic [PW-1:0]                w_prod [2];
    logic signed [SW-1:0]         w_sref [2];
    logic                         r_v2;
    qmd_pkg::t_acc_in             r_req2;

    logic                         w_v4;
    qmd_pkg::t_baud_sums          w_sums;
    logic                         w_rdy4;

    qmd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // stage 0: phase, baud count, table address folding
    assign w_step = PB'(w_cfg.phase_step);
    assign w_spb  = (w_cfg.samples_per_baud == '0) ? qmd_pkg::SPB_W'(1)
                                                   : w_cfg.samples_per_baud;

    always_comb begin
        n_cnt = r_cnt + qmd_pkg::SPB_W'(1);
        w_end = (n_cnt >= w_spb) || (n_cnt == '0) || i_smp.final_sample;
        for (int l = 0; l < 2; l++) begin
            w_ph[l]   = r_phase + REF_OFF[l];
            w_wide[l] = {w_ph[l], {LD{1'b0}}};
            w_idx[l]  = w_wide[l][PB+LD-1 -: LD];
            w_addr[l] = w_idx[l][LD-2] ? AW'(QD) - AW'(w_idx[l][LD-3:0])
                                       : AW'(w_idx[l][LD-3:0]);
            w_neg[l]  = w_idx[l][LD-1];
        end
    end

    assign w_rdy2      = !r_v2 || w_rdy3;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign w_acc       = i_smp.valid && w_rdy1;
    assign i_smp.ready = w_rdy1;

    qmd_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (w_rdy1),
        .i_addr_a (w_addr[0]),
        .i_addr_b (w_addr[1]),
        .o_mag_a  (w_mag[0]),
        .o_mag_b  (w_mag[1])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_cnt   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_smp.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_acc) begin
                r_phase <= r_phase - w_step;
                r_cnt   <= w_end ? '0 : n_cnt;
            end
        end
    end

    // stage 2: amplitude scaling
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_prod[l] = PW'(w_cfg.amplitude) * PW'(w_mag[l]);
            w_sref[l] = r_neg1[l] ? -$signed({1'b0, w_prod[l][PW-1:MW]})
                                  :  $signed({1'b0, w_prod[l][PW-1:MW]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_smp1 <= i_smp.sample;
            r_fin1 <= i_smp.final_sample;
            r_end1 <= w_end;
            r_neg1 <= w_neg;
        end
        if (w_rdy2) begin
            r_req2.sample   <= r_smp1;
            r_req2.sref0    <= w_sref[0];
            r_req2.sref1    <= w_sref[1];
            r_req2.end_baud <= r_end1;
            r_req2.fin      <= r_fin1;
        end
    end

    qmd_dist_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_req   (r_req2),
        .o_ready (w_rdy3),
        .o_valid (w_v4),
        .o_sums  (w_sums),
        .i_ready (w_rdy4)
    );

    qmd_decide u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v4),
        .i_sums  (w_sums),
        .o_ready (w_rdy4),
        .o_sym   (o_sym)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_end) |=> (r_cnt == '0))
        else $error("baud count not cleared at end of baud");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_end) |=> (r_cnt != '0))
        else $error("baud count lost a sample");

endmodule
